@@ hw/rtl/ckci_pkg.sv @@
// Shared types and constants for the cyclic keyframe color interpolator.
// No dependencies; the interface, divider, interpolator and testbench top refer to it by scoped names.
package ckci_pkg;
   localparam int TIME_W  = 16;
   localparam int CHAN_W  = 16;
   localparam int RATIO_W = 17;
   localparam int NUM_W   = 18;
   localparam logic [15:0] DAY_RESET = 16'd2880;

   typedef enum logic [1:0] {
      OP_WRITE_KEY = 2'd0,
      OP_SET_COUNT = 2'd1,
      OP_QUERY     = 2'd2,
      OP_NONE      = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_LAST,
      ST_SCAN,
      ST_DIV,
      ST_BLEND
   } state_type;
endpackage

@@ hw/rtl/ckci_if.sv @@
// Handshake channels of the interpolator: request, response and register write.
// Depends on ckci_pkg for the color channel width of the response.
interface ckci_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [4:0]  row;
   logic [3:0]  key_index;
   logic [15:0] key_time;
   logic [15:0] key_red;
   logic [15:0] key_green;
   logic [15:0] key_blue;
   logic [4:0]  key_count;
   logic [15:0] query_time;
   modport source (output valid, op, row, key_index, key_time, key_red, key_green,
                   key_blue, key_count, query_time, input ready);
   modport sink (input valid, op, row, key_index, key_time, key_red, key_green,
                 key_blue, key_count, query_time, output ready);
endinterface

interface ckci_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic signed [4:0] key_position;
   logic [ckci_pkg::CHAN_W-1:0] out_red;
   logic [ckci_pkg::CHAN_W-1:0] out_green;
   logic [ckci_pkg::CHAN_W-1:0] out_blue;
   modport source (output valid, found, key_position, out_red, out_green, out_blue,
                   input ready);
   modport sink (input valid, found, key_position, out_red, out_green, out_blue,
                 output ready);
endinterface

interface ckci_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

@@ hw/rtl/ckci_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ckci_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 288
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

@@ hw/rtl/ckci_div.sv @@
// Blend ratio unit: floor(num*65536/den) clamped to 0..65536, one quotient bit a cycle.
// Depends on ckci_pkg for widths.
module ckci_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [ckci_pkg::NUM_W-1:0]   num,
   input  logic signed [ckci_pkg::NUM_W-1:0]   den,
   output logic                                done,
   output logic [ckci_pkg::RATIO_W-1:0]        ratio
);
   localparam int REM_W = ckci_pkg::NUM_W + 1;

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [4:0]                    step_ff, step_in;
   logic [REM_W-1:0]              rem_ff, rem_in;
   logic [REM_W-1:0]              den_ff, den_in;
   logic [ckci_pkg::RATIO_W-1:0]  quo_ff, quo_in;
   logic [REM_W-1:0]              rem2;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      rem2    = {rem_ff[REM_W-2:0], 1'b0};
      if (start) begin
         if (den <= 0 || num <= 0) begin
            quo_in  = '0;
            done_in = 1'b1;
         end else if (num >= den) begin
            quo_in  = ckci_pkg::RATIO_W'(65536);
            done_in = 1'b1;
         end else begin
            rem_in  = REM_W'(unsigned'(num));
            den_in  = REM_W'(unsigned'(den));
            quo_in  = '0;
            step_in = 5'd16;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (rem2 >= den_ff) begin
            rem_in = rem2 - den_ff;
            quo_in = {quo_ff[ckci_pkg::RATIO_W-2:0], 1'b1};
         end else begin
            rem_in = rem2;
            quo_in = {quo_ff[ckci_pkg::RATIO_W-2:0], 1'b0};
         end
         step_in = step_ff - 5'd1;
         if (step_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done  = done_ff;
   assign ratio = quo_ff;
endmodule

@@ hw/rtl/cyclic_keyframe_color_interp.sv @@
// Cyclic keyframe color interpolator. A key write or count write completes when accepted.
// A query for an invalid or empty row goes straight to the blend step; a single key
// is read and blended; otherwise the first and last keys are read from the key RAM,
// the scan reads up to MAX_KEYS-1 keys, the bit-serial divider forms the ratio
// (without its bit loop when the ratio clamps) and the blend holds while a response waits.
// Synchronous reset clears the row counts, the sequencer and day_length (2880).
module cyclic_keyframe_color_interp #(
   parameter int ROW_COUNT = 18,
   parameter int MAX_KEYS  = 16
) (
   input  logic          clock,
   input  logic          reset,
   ckci_req_if.sink      req_bus,
   ckci_rsp_if.source    rsp_bus,
   ckci_csr_if.sink      csr_bus
);
   localparam int SLOTS  = ROW_COUNT * MAX_KEYS;
   localparam int ADDR_W = $clog2(SLOTS);
   localparam int KW     = $clog2(MAX_KEYS);
   localparam int CNT_W  = $clog2(MAX_KEYS + 1);
   localparam int RIDX_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
   localparam int CW     = ckci_pkg::CHAN_W;
   localparam int KEY_W  = ckci_pkg::TIME_W + 3 * CW;
   localparam int NW     = ckci_pkg::NUM_W;

   ckci_pkg::state_type state_ff, state_in;
   logic [15:0]        day_ff;
   logic [CNT_W-1:0]   cnt_ff [ROW_COUNT];
   logic [15:0]        q_ff, q_in;
   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [KW-1:0]      idx_ff, idx_in;
   logic [KW-1:0]      last_ff, last_in;
   logic               one_ff, one_in;
   logic               found_ff, found_in;
   logic [KEY_W-1:0]   k0_ff, k0_in;
   logic [KEY_W-1:0]   prev_ff, prev_in;
   logic [3*CW-1:0]    ca_ff, ca_in, cb_ff, cb_in;
   logic [4:0]         pos_ff, pos_in;
   logic [ckci_pkg::RATIO_W-1:0] ratio_ff, ratio_in;
   logic               rsp_valid_ff;
   logic               rsp_found_ff;
   logic [4:0]         rsp_pos_ff;
   logic [CW-1:0]      rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic               rsp_load;
   logic [CW-1:0]      blend_chan [3];

   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
   logic [KEY_W-1:0]   ram_rdata;
   logic               div_start, div_done;
   logic signed [NW-1:0] div_num, div_den;
   logic [ckci_pkg::RATIO_W-1:0] div_ratio;

   logic               req_fire, row_ok;
   logic [CNT_W-1:0]   req_cnt;
   logic [ADDR_W-1:0]  req_base;
   logic signed [NW-1:0] sq, sdl, st0, stl, scur, sprev;
   logic [15:0]        cur_t;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign row_ok   = 32'(req_bus.row) < ROW_COUNT;
   assign req_cnt  = row_ok ? cnt_ff[req_bus.row[RIDX_W-1:0]] : '0;
   assign req_base = ADDR_W'(32'(req_bus.row) * MAX_KEYS);
   assign req_bus.ready = (state_ff == ckci_pkg::ST_IDLE);
   assign csr_bus.ready = 1'b1;

   assign ram_we    = req_fire && req_bus.op == ckci_pkg::OP_WRITE_KEY && row_ok
                      && 32'(req_bus.key_index) < MAX_KEYS;
   assign ram_waddr = ADDR_W'(32'(req_base) + 32'(req_bus.key_index));

   ckci_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_keys (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data ({req_bus.key_time, req_bus.key_red, req_bus.key_green, req_bus.key_blue}),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   ckci_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .ratio (div_ratio)
   );

   assign cur_t = ram_rdata[KEY_W-1 -: 16];
   assign sq    = NW'(q_ff);
   assign sdl   = NW'(day_ff);
   assign st0   = NW'(k0_ff[KEY_W-1 -: 16]);
   assign stl   = NW'(cur_t);
   assign scur  = NW'(cur_t);
   assign sprev = NW'(prev_ff[KEY_W-1 -: 16]);

   always_comb begin
      state_in  = state_ff;
      q_in      = q_ff;
      base_in   = base_ff;
      idx_in    = idx_ff;
      last_in   = last_ff;
      one_in    = one_ff;
      found_in  = found_ff;
      k0_in     = k0_ff;
      prev_in   = prev_ff;
      ca_in     = ca_ff;
      cb_in     = cb_ff;
      pos_in    = pos_ff;
      ratio_in  = ratio_ff;
      ram_raddr = base_ff;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      rsp_load  = 1'b0;
      case (state_ff)
         ckci_pkg::ST_IDLE: begin
            ram_raddr = req_base;
            if (req_fire && req_bus.op == ckci_pkg::OP_QUERY) begin
               q_in    = req_bus.query_time;
               base_in = req_base;
               last_in = KW'(req_cnt - CNT_W'(1));
               one_in  = (req_cnt == CNT_W'(1));
               if (!row_ok || req_cnt == '0) begin
                  found_in = 1'b0;
                  pos_in   = 5'h1F;
                  state_in = ckci_pkg::ST_BLEND;
               end else begin
                  found_in = 1'b1;
                  state_in = ckci_pkg::ST_FIRST;
               end
            end
         end
         ckci_pkg::ST_FIRST: begin
            k0_in     = ram_rdata;
            ram_raddr = ADDR_W'(32'(base_ff) + 32'(last_ff));
            if (one_ff) begin
               ca_in    = ram_rdata[3*CW-1:0];
               cb_in    = ram_rdata[3*CW-1:0];
               ratio_in = '0;
               pos_in   = '0;
               state_in = ckci_pkg::ST_BLEND;
            end else begin
               state_in = ckci_pkg::ST_LAST;
            end
         end
         ckci_pkg::ST_LAST: begin
            ram_raddr = ADDR_W'(32'(base_ff) + 1);
            // Outside the key span the blend runs from the last key to the first.
            if (q_ff <= k0_ff[KEY_W-1 -: 16] || q_ff >= cur_t) begin
               ca_in     = ram_rdata[3*CW-1:0];
               cb_in     = k0_ff[3*CW-1:0];
               div_start = 1'b1;
               div_den   = st0 + sdl - stl;
               if (q_ff <= k0_ff[KEY_W-1 -: 16]) begin
                  div_num = sq + sdl - stl;
                  pos_in  = '0;
               end else begin
                  div_num = sq - stl;
                  pos_in  = 5'(32'(last_ff));
               end
               state_in = ckci_pkg::ST_DIV;
            end else begin
               prev_in  = k0_ff;
               idx_in   = KW'(1);
               state_in = ckci_pkg::ST_SCAN;
            end
         end
         ckci_pkg::ST_SCAN: begin
            ram_raddr = ADDR_W'(32'(base_ff) + 32'(idx_ff) + 1);
            if (q_ff <= cur_t) begin
               ca_in     = prev_ff[3*CW-1:0];
               cb_in     = ram_rdata[3*CW-1:0];
               div_start = 1'b1;
               div_num   = sq - sprev;
               div_den   = scur - sprev;
               pos_in    = 5'(32'(idx_ff));
               state_in  = ckci_pkg::ST_DIV;
            end else begin
               prev_in = ram_rdata;
               idx_in  = idx_ff + KW'(1);
            end
         end
         ckci_pkg::ST_DIV: begin
            if (div_done) begin
               ratio_in = div_ratio;
               state_in = ckci_pkg::ST_BLEND;
            end
         end
         ckci_pkg::ST_BLEND: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load = 1'b1;
               state_in = ckci_pkg::ST_IDLE;
            end
         end
         default: state_in = ckci_pkg::ST_IDLE;
      endcase
   end

   // Each channel is a + floor((b - a) * ratio / 65536), equal to the weighted sum.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic signed [CW:0]   a_s, diff;
         logic signed [CW+ckci_pkg::RATIO_W+1:0] prod;
         a_s  = signed'({1'b0, ca_ff[k*CW +: CW]});
         diff = signed'({1'b0, cb_ff[k*CW +: CW]}) - a_s;
         prod = diff * signed'({1'b0, ratio_ff});
         blend_chan[k] = CW'(a_s + (CW+1)'(prod >>> 16));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ckci_pkg::ST_IDLE;
         day_ff       <= ckci_pkg::DAY_RESET;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < ROW_COUNT; r++) begin
            cnt_ff[r] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_bus.valid) begin
            day_ff <= csr_bus.data;
         end
         if (req_fire && req_bus.op == ckci_pkg::OP_SET_COUNT && row_ok) begin
            cnt_ff[req_bus.row[RIDX_W-1:0]] <= (32'(req_bus.key_count) > MAX_KEYS)
               ? CNT_W'(MAX_KEYS) : CNT_W'(req_bus.key_count);
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      q_ff     <= q_in;
      base_ff  <= base_in;
      idx_ff   <= idx_in;
      last_ff  <= last_in;
      one_ff   <= one_in;
      found_ff <= found_in;
      k0_ff    <= k0_in;
      prev_ff  <= prev_in;
      ca_ff    <= ca_in;
      cb_ff    <= cb_in;
      pos_ff   <= pos_in;
      ratio_ff <= ratio_in;
      if (rsp_load) begin
         rsp_found_ff <= found_ff;
         rsp_pos_ff   <= pos_ff;
         rsp_red_ff   <= found_ff ? blend_chan[2] : '0;
         rsp_green_ff <= found_ff ? blend_chan[1] : '0;
         rsp_blue_ff  <= found_ff ? blend_chan[0] : '0;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.found        = rsp_found_ff;
   assign rsp_bus.key_position = signed'(rsp_pos_ff);
   assign rsp_bus.out_red      = rsp_red_ff;
   assign rsp_bus.out_green    = rsp_green_ff;
   assign rsp_bus.out_blue     = rsp_blue_ff;
endmodule

@@ test/tb_channels.sv @@
// Testbench-side note: the block's channel interfaces live in hw/rtl/ckci_if.sv.
// This file holds the small record types the testbench uses for one result item and one request item.
`timescale 1ns / 1ps
package tb_ckci_types;
   typedef struct packed {
      logic              found;
      logic signed [4:0] key_position;
      logic [15:0]       out_red;
      logic [15:0]       out_green;
      logic [15:0]       out_blue;
   } color_result;

   typedef struct packed {
      logic [1:0]  op;
      logic [4:0]  row;
      logic [3:0]  key_index;
      logic [15:0] key_time;
      logic [15:0] key_red;
      logic [15:0] key_green;
      logic [15:0] key_blue;
      logic [4:0]  key_count;
      logic [15:0] query_time;
      logic        is_cfg;
      logic        wait_idle;
      logic [15:0] cfg_data;
   } request_item;
endpackage

@@ test/tb_top.sv @@
// Testbench for cyclic_keyframe_color_interp: loads key tables, queries colors
// and checks every response against a behavioral predictor. Depends on ckci_pkg,
// the ckci channel interfaces and tb_ckci_types.
`timescale 1ns / 1ps
module tb_top;
   localparam int ROWS = 18;
   localparam int KEYS = 16;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ckci_req_if req_bus();
   ckci_rsp_if rsp_bus();
   ckci_csr_if csr_bus();

   cyclic_keyframe_color_interp #(.ROW_COUNT(ROWS), .MAX_KEYS(KEYS)) DUT (
      .clock(clock), .reset(reset),
      .req_bus(req_bus), .rsp_bus(rsp_bus), .csr_bus(csr_bus)
   );

   always #5 clock = ~clock;

   // Predictor state.
   logic [15:0] pred_time [ROWS*KEYS];
   logic [47:0] pred_color [ROWS*KEYS];
   logic [4:0]  pred_count [ROWS];
   logic [15:0] pred_day;

   // Testbench shadow of which slots were written, to keep queries legal.
   bit          slot_written [ROWS*KEYS];
   logic [4:0]  plan_count [ROWS];

   tb_ckci_types::request_item pending_items[$];
   tb_ckci_types::color_result expected_colors[$];
   int mismatches = 0;
   int results_seen = 0;
   int queries_sent = 0;
   int cycles = 0;
   bit stimulus_done = 0;
   bit req_taken = 0;
   bit csr_taken = 0;

   function automatic logic [16:0] blend_ratio(longint n, longint d);
      if (d <= 0 || n <= 0) return 17'd0;
      if (n >= d) return 17'd65536;
      return 17'((n * 65536) / d);
   endfunction

   function automatic logic [47:0] mix_colors(logic [47:0] a, logic [47:0] b,
                                               logic [16:0] r);
      logic [47:0] res;
      longint v;
      for (int k = 0; k < 3; k++) begin
         v = (longint'(a[k*16 +: 16]) * (65536 - longint'(r)) +
              longint'(b[k*16 +: 16]) * longint'(r)) >> 16;
         res[k*16 +: 16] = v[15:0];
      end
      return res;
   endfunction

   function automatic tb_ckci_types::color_result predict_query(logic [4:0] row,
                                                                logic [15:0] qt);
      tb_ckci_types::color_result res;
      int base, last, p;
      longint q, dl, t0, tl, ta, tb;
      logic [47:0] c;
      res = '{found: 1'b0, key_position: -5'sd1, default: '0};
      if (row >= ROWS || pred_count[row] == 0) return res;
      base = row * KEYS;
      res.found = 1'b1;
      q = qt;
      dl = pred_day;
      if (pred_count[row] == 1) begin
         res.key_position = '0;
         c = pred_color[base];
      end else begin
         last = pred_count[row] - 1;
         t0 = pred_time[base];
         tl = pred_time[base + last];
         if (q <= t0) begin
            res.key_position = '0;
            c = mix_colors(pred_color[base + last], pred_color[base],
                           blend_ratio(q + dl - tl, t0 + dl - tl));
         end else if (q >= tl) begin
            res.key_position = 5'(last);
            c = mix_colors(pred_color[base + last], pred_color[base],
                           blend_ratio(q - tl, t0 + dl - tl));
         end else begin
            p = last;
            for (int i = last; i >= 1; i--)
               if (q <= longint'(pred_time[base + i])) p = i;
            ta = pred_time[base + p - 1];
            tb = pred_time[base + p];
            res.key_position = 5'(p);
            c = mix_colors(pred_color[base + p - 1], pred_color[base + p],
                           blend_ratio(q - ta, tb - ta));
         end
      end
      res.out_red = c[47:32];
      res.out_green = c[31:16];
      res.out_blue = c[15:0];
      return res;
   endfunction

   // Stimulus builders; they keep plan_count and slot_written in step with
   // what the block will hold, so no query reads an unwritten slot.
   task automatic push_write(int row, int idx, logic [15:0] t, logic [47:0] c);
      tb_ckci_types::request_item it;
      it = '0;
      it.op = ckci_pkg::OP_WRITE_KEY;
      it.row = 5'(row);
      it.key_index = 4'(idx);
      it.key_time = t;
      {it.key_red, it.key_green, it.key_blue} = c;
      if (row < ROWS) slot_written[row*KEYS + idx] = 1;
      pending_items.push_back(it);
   endtask

   task automatic push_count(int row, int cnt);
      tb_ckci_types::request_item it;
      it = '0;
      it.op = ckci_pkg::OP_SET_COUNT;
      it.row = 5'(row);
      it.key_count = 5'(cnt);
      if (row < ROWS) plan_count[row] = (cnt > KEYS) ? 5'(KEYS) : 5'(cnt);
      pending_items.push_back(it);
   endtask

   task automatic push_query(int row, logic [15:0] qt);
      tb_ckci_types::request_item it;
      it = '0;
      it.op = ckci_pkg::OP_QUERY;
      it.row = 5'(row);
      it.query_time = qt;
      pending_items.push_back(it);
   endtask

   task automatic push_other(logic [1:0] op, logic [4:0] row, logic [3:0] idx);
      tb_ckci_types::request_item it;
      it = '0;
      it.op = op;
      it.row = row;
      it.key_index = idx;
      it.key_time = 16'($urandom);
      it.key_red = 16'($urandom);
      it.key_green = 16'($urandom);
      it.key_blue = 16'($urandom);
      it.key_count = 5'($urandom);
      it.query_time = 16'($urandom);
      pending_items.push_back(it);
   endtask

   task automatic push_day(logic [15:0] d);
      tb_ckci_types::request_item it;
      it = '0;
      it.is_cfg = 1;
      it.cfg_data = d;
      pending_items.push_back(it);
   endtask

   task automatic push_drain();
      tb_ckci_types::request_item it;
      it = '0;
      it.wait_idle = 1;
      pending_items.push_back(it);
   endtask

   // Loads a row with n keys, sorted unless told otherwise.
   task automatic load_row(int row, int n, bit sorted);
      int t;
      t = $urandom_range(0, 400);
      for (int i = 0; i < n; i++) begin
         push_write(row, i, sorted ? 16'(t) : 16'($urandom),
                    {16'($urandom), 16'($urandom), 16'($urandom)});
         t += $urandom_range(0, 300);
      end
      push_count(row, n);
   endtask

   function automatic bit row_queryable(int row);
      if (row >= ROWS) return 1;
      for (int i = 0; i < plan_count[row]; i++)
         if (!slot_written[row*KEYS + i]) return 0;
      return 1;
   endfunction

   // Fills the queue of pending items.
   initial begin
      int row, r;
      foreach (plan_count[i]) plan_count[i] = 0;
      foreach (slot_written[i]) slot_written[i] = 0;
      // Directed part.
      push_query(0, 16'd100);
      push_query(31, 16'hFFFF);
      push_write(1, 0, 16'd500, 48'hFFFF_0000_8000);
      push_count(1, 1);
      push_query(1, 16'd0);
      push_write(2, 0, 16'd100, 48'h0000_0000_0000);
      push_write(2, 1, 16'd1000, 48'hFFFF_FFFF_FFFF);
      push_write(2, 15, 16'hFFFF, 48'h1234_5678_9ABC);
      push_count(2, 2);
      push_query(2, 16'd100);
      push_query(2, 16'd550);
      push_query(2, 16'd1000);
      push_query(2, 16'd2000);
      push_query(2, 16'd0);
      push_write(20, 3, 16'd7, 48'h0);
      push_write(2, 2, 16'd50, 48'hAAAA_5555_0F0F);
      push_count(2, 3);
      push_query(2, 16'd70);
      push_count(25, 4);
      push_other(ckci_pkg::OP_NONE, 5'd2, 4'd0);
      push_count(2, 31);
      push_count(2, 2);
      push_query(2, 16'hFFFF);
      push_drain();
      push_day(16'd1);
      push_query(2, 16'd5);
      push_drain();
      push_day(16'hFFFF);
      push_query(2, 16'd5000);
      push_drain();
      push_day(16'd2880);
      // Random part: mostly sorted tables with queries, some noise.
      for (int i = 0; i < 240; i++) begin
         r = $urandom_range(0, 99);
         row = $urandom_range(0, ROWS - 1);
         if (i % 100 == 99) begin
            push_drain();
            push_day(16'($urandom_range(1, 65535)));
         end else if (r < 8) begin
            load_row(row, $urandom_range(1, KEYS), $urandom_range(0, 4) != 0);
         end else if (r < 11) begin
            push_other(ckci_pkg::OP_NONE, 5'($urandom), 4'($urandom));
         end else if (r < 14) begin
            push_write($urandom_range(ROWS, 31), $urandom_range(0, 15), 16'($urandom),
                       {16'($urandom), 16'($urandom), 16'($urandom)});
         end else if (r < 17) begin
            row = $urandom_range(0, 31);
            if (row >= ROWS) push_count(row, $urandom_range(0, 31));
            else push_count(row, 0);
         end else if (r < 20) begin
            push_write(row, $urandom_range(0, 15), 16'($urandom),
                       {16'($urandom), 16'($urandom), 16'($urandom)});
         end else begin
            row = ($urandom_range(0, 9) == 0) ? $urandom_range(ROWS, 31) : row;
            if (row_queryable(row)) begin
               case ($urandom_range(0, 2))
                  0: push_query(row, 16'($urandom));
                  1: push_query(row, 16'($urandom_range(0, 4000)));
                  default: push_query(row, ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0);
               endcase
            end
         end
      end
   end

   // Driver: bursts with random gaps; drain markers hold off until idle.
   int gap_left = 0;
   int burst_left = 0;
   int drain_pause = 0;
   tb_ckci_types::request_item cur;

   initial begin
      req_bus.valid = 0;
      req_bus.op = ckci_pkg::OP_NONE;
      req_bus.row = 0;
      req_bus.key_index = 0;
      req_bus.key_time = 0;
      req_bus.key_red = 0;
      req_bus.key_green = 0;
      req_bus.key_blue = 0;
      req_bus.key_count = 0;
      req_bus.query_time = 0;
      csr_bus.valid = 0;
      csr_bus.data = 0;
      rsp_bus.ready = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;
   end

   // Handshakes are recorded at the rising edge where they take place.
   always @(posedge clock) begin
      req_taken = !reset && req_bus.valid && req_bus.ready;
      csr_taken = !reset && csr_bus.valid && csr_bus.ready;
   end

   always @(negedge clock) begin
      bit req_load, csr_load, req_wait, csr_wait;
      req_load = 0;
      csr_load = 0;
      if (!reset) begin
         if (req_taken) begin
            if (req_bus.op == ckci_pkg::OP_QUERY)
               expected_colors.push_back(predict_query(req_bus.row, req_bus.query_time));
            else if (req_bus.op == ckci_pkg::OP_WRITE_KEY && req_bus.row < ROWS) begin
               pred_time[req_bus.row*KEYS + req_bus.key_index] = req_bus.key_time;
               pred_color[req_bus.row*KEYS + req_bus.key_index] =
                  {req_bus.key_red, req_bus.key_green, req_bus.key_blue};
            end else if (req_bus.op == ckci_pkg::OP_SET_COUNT && req_bus.row < ROWS)
               pred_count[req_bus.row] = (req_bus.key_count > KEYS) ? 5'(KEYS)
                                                                    : req_bus.key_count;
         end
         if (csr_taken) pred_day = csr_bus.data;
         req_wait = req_bus.valid && !req_taken;
         csr_wait = csr_bus.valid && !csr_taken;
         if (!req_wait && !csr_wait && pending_items.size() > 0) begin
            if (pending_items[0].wait_idle) begin
               // Writes and counts make no response, so give the block time to settle.
               if (expected_colors.size() == 0) begin
                  drain_pause++;
                  if (drain_pause > 40) begin
                     void'(pending_items.pop_front());
                     drain_pause = 0;
                  end
               end
            end else if (gap_left > 0) begin
               gap_left--;
            end else begin
               cur = pending_items.pop_front();
               if (cur.is_cfg) begin
                  csr_bus.data <= cur.cfg_data;
                  csr_load = 1;
               end else begin
                  req_bus.op <= cur.op;
                  req_bus.row <= cur.row;
                  req_bus.key_index <= cur.key_index;
                  req_bus.key_time <= cur.key_time;
                  req_bus.key_red <= cur.key_red;
                  req_bus.key_green <= cur.key_green;
                  req_bus.key_blue <= cur.key_blue;
                  req_bus.key_count <= cur.key_count;
                  req_bus.query_time <= cur.query_time;
                  req_load = 1;
                  if (cur.op == ckci_pkg::OP_QUERY) queries_sent++;
               end
               if (burst_left > 0) burst_left--;
               else begin
                  burst_left = $urandom_range(0, 12);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
         if (req_load) req_bus.valid <= 1;
         else if (req_taken) req_bus.valid <= 0;
         if (csr_load) csr_bus.valid <= 1;
         else if (csr_taken) csr_bus.valid <= 0;
         if (pending_items.size() == 0 && !req_load && !csr_load && !req_wait && !csr_wait)
            stimulus_done = 1;
         // Receiver stall pattern: long ready stretches mixed with stall runs.
         rsp_bus.ready <= ((cycles / 64) % 3 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
   end

   // Initialize predictor state at reset.
   initial begin
      foreach (pred_count[i]) pred_count[i] = 0;
      foreach (pred_time[i]) pred_time[i] = 0;
      foreach (pred_color[i]) pred_color[i] = 0;
      pred_day = ckci_pkg::DAY_RESET;
   end

   // Monitor.
   always @(posedge clock) begin
      tb_ckci_types::color_result got, want;
      cycles <= cycles + 1;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{found: rsp_bus.found, key_position: rsp_bus.key_position,
                 out_red: rsp_bus.out_red, out_green: rsp_bus.out_green,
                 out_blue: rsp_bus.out_blue};
         results_seen++;
         if (expected_colors.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected response item: %p", got);
         end else begin
            want = expected_colors.pop_front();
            if (got.found !== want.found || got.key_position !== want.key_position ||
                got.out_red !== want.out_red || got.out_green !== want.out_green ||
                got.out_blue !== want.out_blue) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Color mismatch: expected %p, got %p", want, got);
            end
         end
      end
   end

   initial begin
      int tail;
      tail = 0;
      wait (reset == 0);
      while (!(stimulus_done && expected_colors.size() == 0) && cycles < CYCLE_LIMIT)
         @(posedge clock);
      while (tail < 60 && cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         tail++;
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("Verification failed");
      end else begin
         $display("Run covered %0d queries and %0d checked responses over %0d cycles.",
                  queries_sent, results_seen, cycles);
         if (mismatches == 0 && expected_colors.size() == 0) begin
            $display("Verification passed");
         end else begin
            $display("Verification failed");
         end
      end
      $finish;
   end
endmodule
